@@ hw/rtl/half_space_triangle_rasterizer_assert.svh @@
// Assertion macros used by the rasterizer sequencer.
`ifndef HALF_SPACE_TRIANGLE_RASTERIZER_ASSERT_SVH
`define HALF_SPACE_TRIANGLE_RASTERIZER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HSTR_ASSERT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rasterizer assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define HSTR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rasterizer assertion failed");

`endif

@@ hw/rtl/hstr_pkg.sv @@
package hstr_pkg;

    localparam int CRD_W     = 10;
    localparam int FRAC_W    = 4;
    localparam int PX_W      = 7;
    localparam int ROW_W     = 6;
    localparam int COV_W     = 64;
    localparam int OPD_W     = 12;
    localparam int PRD_W     = 2 * OPD_W;
    localparam int EDGE_W    = 25;
    localparam int NUM_EDGES = 3;

    localparam logic [CRD_W:0] ROUND_ADD = (CRD_W + 1)'(15);

    typedef logic [CRD_W-1:0] t_coord;
    typedef logic [PX_W-1:0]  t_px;

    typedef enum logic [2:0] {
        EU_C_PX,
        EU_C_PY,
        EU_Y0,
        EU_X0,
        EU_STEP_X,
        EU_STEP_Y
    } t_eu_op;

    typedef struct packed {
        logic   en;
        logic   row_wr;
        t_eu_op op;
    } t_eu_ctrl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_C_PX,
        ST_C_PY,
        ST_Y0,
        ST_X0,
        ST_WALK,
        ST_EMIT,
        ST_NEXT
    } t_state;

    // Pixel bound of a fixed-point coordinate, rounded up.
    function automatic t_px px_ceil(input t_coord v);
        logic [CRD_W:0] s;
        s = {1'b0, v} + ROUND_ADD;
        return PX_W'(s >> FRAC_W);
    endfunction

endpackage

@@ hw/rtl/hstr_edge_unit.sv @@
module hstr_edge_unit (
    input  logic              i_clk,
    input  hstr_pkg::t_eu_ctrl i_ctrl,
    input  hstr_pkg::t_coord  i_ax,
    input  hstr_pkg::t_coord  i_ay,
    input  hstr_pkg::t_coord  i_bx,
    input  hstr_pkg::t_coord  i_by,
    input  hstr_pkg::t_coord  i_cx,
    input  hstr_pkg::t_coord  i_cy,
    input  hstr_pkg::t_px     i_minx,
    input  hstr_pkg::t_px     i_miny,
    output logic              o_inside
);
    import hstr_pkg::*;

    t_coord                   w_px [NUM_EDGES];
    t_coord                   w_py [NUM_EDGES];
    t_coord                   w_qx [NUM_EDGES];
    t_coord                   w_qy [NUM_EDGES];
    logic signed [OPD_W-1:0]  w_dx [NUM_EDGES];
    logic signed [OPD_W-1:0]  w_dy [NUM_EDGES];
    logic                     w_tl [NUM_EDGES];
    logic signed [EDGE_W-1:0] w_acc [NUM_EDGES];
    logic signed [OPD_W-1:0]  w_opa [NUM_EDGES];
    logic signed [OPD_W-1:0]  w_opb [NUM_EDGES];
    logic                     w_cin [NUM_EDGES];
    logic signed [PRD_W-1:0]  w_prod [NUM_EDGES];
    logic signed [EDGE_W-1:0] w_sum [NUM_EDGES];
    logic signed [EDGE_W-1:0] r_e [NUM_EDGES];
    logic signed [EDGE_W-1:0] r_row [NUM_EDGES];
    logic signed [OPD_W-1:0]  w_minx16;
    logic signed [OPD_W-1:0]  w_miny16;

    assign w_minx16 = $signed({1'b0, i_minx, 4'b0000});
    assign w_miny16 = $signed({1'b0, i_miny, 4'b0000});

    always_comb begin
        w_px[0] = i_ax; w_py[0] = i_ay; w_qx[0] = i_bx; w_qy[0] = i_by;
        w_px[1] = i_bx; w_py[1] = i_by; w_qx[1] = i_cx; w_qy[1] = i_cy;
        w_px[2] = i_cx; w_py[2] = i_cy; w_qx[2] = i_ax; w_qy[2] = i_ay;
        for (int i = 0; i < NUM_EDGES; i++) begin
            w_dx[i] = $signed({2'b00, w_px[i]}) - $signed({2'b00, w_qx[i]});
            w_dy[i] = $signed({2'b00, w_py[i]}) - $signed({2'b00, w_qy[i]});
            // Top-left edges get one unit added to their edge constant, so a pixel exactly on them counts as inside.
            w_tl[i] = w_dy[i][OPD_W-1] || ((w_dy[i] == '0) && !w_dx[i][OPD_W-1]
                      && (w_dx[i] != '0));
            w_cin[i] = 1'b0;
            case (i_ctrl.op)
                EU_C_PX: begin
                    w_acc[i] = '0;
                    w_opa[i] = w_dy[i];
                    w_opb[i] = $signed({2'b00, w_px[i]});
                end
                EU_C_PY: begin
                    w_acc[i] = r_e[i];
                    w_opa[i] = -w_dx[i];
                    w_opb[i] = $signed({2'b00, w_py[i]});
                    w_cin[i] = w_tl[i];
                end
                EU_Y0: begin
                    w_acc[i] = r_e[i];
                    w_opa[i] = w_dx[i];
                    w_opb[i] = w_miny16;
                end
                EU_X0: begin
                    w_acc[i] = r_e[i];
                    w_opa[i] = -w_dy[i];
                    w_opb[i] = w_minx16;
                end
                EU_STEP_X: begin
                    w_acc[i] = r_e[i];
                    w_opa[i] = -w_dy[i];
                    w_opb[i] = OPD_W'(16);
                end
                EU_STEP_Y: begin
                    w_acc[i] = r_row[i];
                    w_opa[i] = w_dx[i];
                    w_opb[i] = OPD_W'(16);
                end
                default: begin
                    w_acc[i] = r_e[i];
                    w_opa[i] = '0;
                    w_opb[i] = '0;
                end
            endcase
            w_prod[i] = w_opa[i] * w_opb[i];
            w_sum[i]  = w_acc[i] + EDGE_W'(w_prod[i]) + EDGE_W'({1'b0, w_cin[i]});
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NUM_EDGES; i++) begin
            if (i_ctrl.en) begin
                r_e[i] <= w_sum[i];
            end
            if (i_ctrl.en && i_ctrl.row_wr) begin
                r_row[i] <= w_sum[i];
            end
        end
    end

    assign o_inside = !r_e[0][EDGE_W-1] && (r_e[0] != '0)
                   && !r_e[1][EDGE_W-1] && (r_e[1] != '0)
                   && !r_e[2][EDGE_W-1] && (r_e[2] != '0);

endmodule

@@ hw/rtl/hstr_seq.sv @@
`include "half_space_triangle_rasterizer_assert.svh"

module hstr_seq #(
    parameter int SCREEN_WIDTH  = 64,
    parameter int SCREEN_HEIGHT = 64
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  hstr_pkg::t_coord         i_ax,
    input  hstr_pkg::t_coord         i_ay,
    input  hstr_pkg::t_coord         i_bx,
    input  hstr_pkg::t_coord         i_by,
    input  hstr_pkg::t_coord         i_cx,
    input  hstr_pkg::t_coord         i_cy,
    input  logic                     i_inside,
    output hstr_pkg::t_eu_ctrl       o_ctrl,
    output hstr_pkg::t_px            o_minx,
    output hstr_pkg::t_px            o_miny,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic [hstr_pkg::ROW_W-1:0] o_row,
    output logic [SCREEN_WIDTH-1:0]  o_coverage,
    output logic                     o_last_row
);
    import hstr_pkg::*;

    localparam int  XIW    = $clog2(SCREEN_WIDTH);
    localparam t_px MAX_X  = PX_W'(SCREEN_WIDTH);
    localparam t_px MAX_Y  = PX_W'(SCREEN_HEIGHT);

    t_state                  r_state, n_state;
    t_px                     r_minx, n_minx;
    t_px                     r_maxx, n_maxx;
    t_px                     r_miny, n_miny;
    t_px                     r_maxy, n_maxy;
    t_px                     r_x, n_x;
    t_px                     r_y, n_y;
    logic [SCREEN_WIDTH-1:0] r_mask, n_mask;
    logic                    r_out_valid, n_out_valid;
    logic [ROW_W-1:0]        r_out_row, n_out_row;
    logic [SCREEN_WIDTH-1:0] r_out_cov, n_out_cov;
    logic                    r_out_last, n_out_last;
    t_coord                  w_lox, w_hix, w_loy, w_hiy;
    t_px                     w_bx_hi, w_by_hi;
    t_px                     w_y_inc;
    t_px                     w_x_inc;
    logic                    w_last;
    logic                    w_out_free;

    always_comb begin
        w_lox = (i_ax < i_bx) ? i_ax : i_bx;
        w_lox = (w_lox < i_cx) ? w_lox : i_cx;
        w_hix = (i_ax > i_bx) ? i_ax : i_bx;
        w_hix = (w_hix > i_cx) ? w_hix : i_cx;
        w_loy = (i_ay < i_by) ? i_ay : i_by;
        w_loy = (w_loy < i_cy) ? w_loy : i_cy;
        w_hiy = (i_ay > i_by) ? i_ay : i_by;
        w_hiy = (w_hiy > i_cy) ? w_hiy : i_cy;
        w_bx_hi = px_ceil(w_hix);
        w_by_hi = px_ceil(w_hiy);
    end

    assign w_y_inc    = r_y + PX_W'(1);
    assign w_x_inc    = r_x + PX_W'(1);
    assign w_last     = (w_y_inc == r_maxy);
    assign w_out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_minx     <= n_minx;
        r_maxx     <= n_maxx;
        r_miny     <= n_miny;
        r_maxy     <= n_maxy;
        r_x        <= n_x;
        r_y        <= n_y;
        r_mask     <= n_mask;
        r_out_row  <= n_out_row;
        r_out_cov  <= n_out_cov;
        r_out_last <= n_out_last;
    end

    always_comb begin
        n_state     = r_state;
        n_minx      = r_minx;
        n_maxx      = r_maxx;
        n_miny      = r_miny;
        n_maxy      = r_maxy;
        n_x         = r_x;
        n_y         = r_y;
        n_mask      = r_mask;
        n_out_valid = r_out_valid;
        n_out_row   = r_out_row;
        n_out_cov   = r_out_cov;
        n_out_last  = r_out_last;
        o_in_ready  = 1'b0;
        o_ctrl      = '{en: 1'b0, row_wr: 1'b0, op: EU_STEP_X};

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_state = ST_C_PX;
                end
            end
            ST_C_PX: begin
                o_ctrl  = '{en: 1'b1, row_wr: 1'b0, op: EU_C_PX};
                n_minx  = px_ceil(w_lox);
                n_maxx  = (w_bx_hi > MAX_X) ? MAX_X : w_bx_hi;
                n_miny  = px_ceil(w_loy);
                n_maxy  = (w_by_hi > MAX_Y) ? MAX_Y : w_by_hi;
                n_state = ST_C_PY;
            end
            ST_C_PY: begin
                o_ctrl  = '{en: 1'b1, row_wr: 1'b0, op: EU_C_PY};
                n_state = (r_maxy <= r_miny) ? ST_IDLE : ST_Y0;
            end
            ST_Y0: begin
                o_ctrl  = '{en: 1'b1, row_wr: 1'b0, op: EU_Y0};
                n_state = ST_X0;
            end
            ST_X0: begin
                o_ctrl  = '{en: 1'b1, row_wr: 1'b1, op: EU_X0};
                n_x     = r_minx;
                n_y     = r_miny;
                n_mask  = '0;
                n_state = (r_minx < r_maxx) ? ST_WALK : ST_EMIT;
            end
            ST_WALK: begin
                o_ctrl = '{en: 1'b1, row_wr: 1'b0, op: EU_STEP_X};
                if (i_inside) begin
                    n_mask[r_x[XIW-1:0]] = 1'b1;
                end
                n_x = w_x_inc;
                if (w_x_inc == r_maxx) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_row   = r_y[ROW_W-1:0];
                    n_out_cov   = r_mask;
                    n_out_last  = w_last;
                    n_state     = w_last ? ST_IDLE : ST_NEXT;
                end
            end
            ST_NEXT: begin
                o_ctrl  = '{en: 1'b1, row_wr: 1'b1, op: EU_STEP_Y};
                n_y     = w_y_inc;
                n_x     = r_minx;
                n_mask  = '0;
                n_state = (r_minx < r_maxx) ? ST_WALK : ST_EMIT;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_minx      = r_minx;
    assign o_miny      = r_miny;
    assign o_out_valid = r_out_valid;
    assign o_row       = r_out_row;
    assign o_coverage  = r_out_cov;
    assign o_last_row  = r_out_last;

    `HSTR_ASSERT(a_walk_in_box, i_clk, i_rst_n, r_state == ST_WALK, r_x < r_maxx)
    `HSTR_ASSERT(a_emit_in_box, i_clk, i_rst_n, r_state == ST_EMIT, r_y < r_maxy)
    `HSTR_ASSERT(a_mask_below_x, i_clk, i_rst_n, r_state == ST_WALK, (r_mask >> r_x) == '0)
    `HSTR_ASSERT_NEXT(a_last_row_ends, i_clk, i_rst_n,
        (r_state == ST_EMIT) && w_out_free && w_last, r_state == ST_IDLE)

endmodule

@@ hw/rtl/half_space_triangle_rasterizer.sv @@
// Channel  Direction  Handshake                  Payload
// in       input      i_in_valid / o_in_ready    i_ax i_ay i_bx i_by i_cx i_cy
// out      output     o_out_valid / i_out_ready  o_row o_coverage o_last_row
//
// One shared three-lane multiply-add unit first forms the edge values in four steps and
// then tests one pixel per cycle along each row of the box. A triangle whose box has no
// rows goes back to idle after the C_PX and C_PY steps. A new triangle is taken only
// while the sequencer is idle; a row result sits in an output register, so the sequencer
// stalls on a full register only.
// Reset is synchronous and active low and clears the sequencer state and output valid.
module half_space_triangle_rasterizer #(
    parameter int SCREEN_WIDTH  = 64,
    parameter int SCREEN_HEIGHT = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  hstr_pkg::t_coord              i_ax,
    input  hstr_pkg::t_coord              i_ay,
    input  hstr_pkg::t_coord              i_bx,
    input  hstr_pkg::t_coord              i_by,
    input  hstr_pkg::t_coord              i_cx,
    input  hstr_pkg::t_coord              i_cy,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [hstr_pkg::ROW_W-1:0]    o_row,
    output logic [hstr_pkg::COV_W-1:0]    o_coverage,
    output logic                          o_last_row
);
    import hstr_pkg::*;

    t_coord                  r_ax, r_ay, r_bx, r_by, r_cx, r_cy;
    t_eu_ctrl                w_ctrl;
    t_px                     w_minx;
    t_px                     w_miny;
    logic                    w_inside;
    logic                    w_in_ready;
    logic [SCREEN_WIDTH-1:0] w_cov;

    always_ff @(posedge i_clk) begin
        if (i_in_valid && w_in_ready) begin
            r_ax <= i_ax;
            r_ay <= i_ay;
            r_bx <= i_bx;
            r_by <= i_by;
            r_cx <= i_cx;
            r_cy <= i_cy;
        end
    end

    hstr_seq #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (w_in_ready),
        .i_ax        (r_ax),
        .i_ay        (r_ay),
        .i_bx        (r_bx),
        .i_by        (r_by),
        .i_cx        (r_cx),
        .i_cy        (r_cy),
        .i_inside    (w_inside),
        .o_ctrl      (w_ctrl),
        .o_minx      (w_minx),
        .o_miny      (w_miny),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_row       (o_row),
        .o_coverage  (w_cov),
        .o_last_row  (o_last_row)
    );

    hstr_edge_unit u_edge (
        .i_clk    (i_clk),
        .i_ctrl   (w_ctrl),
        .i_ax     (r_ax),
        .i_ay     (r_ay),
        .i_bx     (r_bx),
        .i_by     (r_by),
        .i_cx     (r_cx),
        .i_cy     (r_cy),
        .i_minx   (w_minx),
        .i_miny   (w_miny),
        .o_inside (w_inside)
    );

    assign o_in_ready = w_in_ready;
    assign o_coverage = COV_W'(w_cov);

endmodule

@@ dv/tb_top.sv @@
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import hstr_pkg::*;

    localparam int SCREEN_W         = 64;
    localparam int SCREEN_H         = 64;
    localparam int WATCHDOG_LIMIT   = 5000;
    localparam int DRAIN_CYCLES     = 200;
    localparam int RANDOM_TRIANGLES = 260;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COV_W-1:0] coverage;
        logic             last_row;
    } t_row_mask;

    logic             i_clk       = 1'b0;
    logic             i_rst_n     = 1'b0;
    logic             i_in_valid  = 1'b0;
    t_coord           i_ax        = '0;
    t_coord           i_ay        = '0;
    t_coord           i_bx        = '0;
    t_coord           i_by        = '0;
    t_coord           i_cx        = '0;
    t_coord           i_cy        = '0;
    logic             i_out_ready = 1'b0;
    logic             o_in_ready;
    logic             o_out_valid;
    logic [ROW_W-1:0] o_row;
    logic [COV_W-1:0] o_coverage;
    logic             o_last_row;

    t_row_mask expected_rows[$];
    t_row_mask want;
    int        mismatches     = 0;
    int        triangles_sent = 0;
    int        rows_checked   = 0;
    int        covered_rows   = 0;
    int        idle_cycles    = 0;
    int        ready_hold     = 0;
    bit        steady         = 1'b0;

    half_space_triangle_rasterizer #(
        .SCREEN_WIDTH (SCREEN_W),
        .SCREEN_HEIGHT(SCREEN_H)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_ax       (i_ax),
        .i_ay       (i_ay),
        .i_bx       (i_bx),
        .i_by       (i_by),
        .i_cx       (i_cx),
        .i_cy       (i_cy),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_row      (o_row),
        .o_coverage (o_coverage),
        .o_last_row (o_last_row)
    );

    always #4ns i_clk = ~i_clk;

    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_coord clamp_coord(input int base, input int spread);
        int v;
        v = base + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
        return t_coord'(v);
    endfunction

    // Edge constant for the edge from p to q, with the top-left bias applied.
    function automatic longint edge_bias(input longint px, input longint py,
                                         input longint qx, input longint qy);
        longint dx;
        longint dy;
        longint c;
        dx = px - qx;
        dy = py - qy;
        c  = dy * px - dx * py;
        if (dy < 0 || (dy == 0 && dx > 0)) c += 1;
        return c;
    endfunction

    function automatic void predict_rows(input t_coord ax, input t_coord ay,
                                         input t_coord bx, input t_coord by,
                                         input t_coord cx, input t_coord cy);
        longint    vx[3];
        longint    vy[3];
        longint    ec[3];
        longint    ex[3];
        longint    ey[3];
        longint    minx, maxx, miny, maxy;
        int        i, j, px, py;
        bit        hit;
        t_row_mask r;
        vx[0] = ax; vy[0] = ay;
        vx[1] = bx; vy[1] = by;
        vx[2] = cx; vy[2] = cy;
        minx = vx[0]; maxx = vx[0];
        miny = vy[0]; maxy = vy[0];
        for (i = 0; i < 3; i++) begin
            j = (i + 1) % 3;
            ex[i] = vx[i] - vx[j];
            ey[i] = vy[i] - vy[j];
            ec[i] = edge_bias(vx[i], vy[i], vx[j], vy[j]);
            if (vx[i] < minx) minx = vx[i];
            if (vx[i] > maxx) maxx = vx[i];
            if (vy[i] < miny) miny = vy[i];
            if (vy[i] > maxy) maxy = vy[i];
        end
        minx = (minx + 15) >>> 4;
        maxx = (maxx + 15) >>> 4;
        miny = (miny + 15) >>> 4;
        maxy = (maxy + 15) >>> 4;
        if (maxx > SCREEN_W) maxx = SCREEN_W;
        if (maxy > SCREEN_H) maxy = SCREEN_H;
        for (py = int'(miny); py < maxy; py++) begin
            r.row      = ROW_W'(py);
            r.coverage = '0;
            for (px = int'(minx); px < maxx; px++) begin
                hit = 1'b1;
                for (i = 0; i < 3; i++) begin
                    if (ec[i] + ex[i] * py * 16 - ey[i] * px * 16 <= 0) hit = 1'b0;
                end
                if (hit) r.coverage[px] = 1'b1;
            end
            r.last_row = (py + 1 >= maxy);
            expected_rows.push_back(r);
        end
    endfunction

    task automatic send_triangle(input t_coord ax, input t_coord ay, input t_coord bx,
                                 input t_coord by, input t_coord cx, input t_coord cy);
        int gap;
        gap = steady ? 0 : idle_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_ax <= ax;
        i_ay <= ay;
        i_bx <= bx;
        i_by <= by;
        i_cx <= cx;
        i_cy <= cy;
        do @(posedge i_clk); while (!o_in_ready);
        predict_rows(ax, ay, bx, by, cx, cy);
        triangles_sent++;
    endtask

    always @(posedge i_clk) begin
        if (steady) begin
            i_out_ready <= 1'b1;
        end else if (ready_hold > 0) begin
            i_out_ready <= 1'b0;
            ready_hold--;
        end else begin
            ready_hold = idle_gap();
            i_out_ready <= (ready_hold == 0);
            if (ready_hold > 0) ready_hold--;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            rows_checked++;
            if (o_coverage != '0) covered_rows++;
            if (expected_rows.size() == 0) begin
                $display("%0t: unexpected row transfer: row %0d coverage %h last_row %b",
                         $realtime, o_row, o_coverage, o_last_row);
                mismatches++;
            end else begin
                want = expected_rows.pop_front();
                if (o_row !== want.row) begin
                    $display("%0t: row expected %0d actual %0d",
                             $realtime, want.row, o_row);
                    mismatches++;
                end
                if (o_coverage !== want.coverage) begin
                    $display("%0t: coverage of row %0d expected %h actual %h",
                             $realtime, want.row, want.coverage, o_coverage);
                    mismatches++;
                end
                if (o_last_row !== want.last_row) begin
                    $display("%0t: last_row of row %0d expected %b actual %b",
                             $realtime, want.row, want.last_row, o_last_row);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles, %0d rows still expected",
                     $realtime, WATCHDOG_LIMIT, expected_rows.size());
            $display("Verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic test_empty_boxes();
        send_triangle(10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0);
        send_triangle(10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023);
        send_triangle(10'd40, 10'd17, 10'd200, 10'd20, 10'd90, 10'd32);
        send_triangle(10'd5, 10'd5, 10'd900, 10'd9, 10'd400, 10'd1);
    endtask

    task automatic test_zero_width();
        send_triangle(10'd100, 10'd0, 10'd100, 10'd1023, 10'd100, 10'd512);
        send_triangle(10'd1023, 10'd1023, 10'd1023, 10'd0, 10'd1023, 10'd300);
        send_triangle(10'd0, 10'd10, 10'd0, 10'd700, 10'd0, 10'd350);
    endtask

    task automatic test_full_screen();
        steady = 1'b1;
        send_triangle(10'd0, 10'd0, 10'd1023, 10'd0, 10'd0, 10'd1023);
        send_triangle(10'd0, 10'd0, 10'd0, 10'd1023, 10'd1023, 10'd0);
        steady = 1'b0;
        send_triangle(10'd1023, 10'd1023, 10'd0, 10'd1023, 10'd1023, 10'd0);
        send_triangle(10'd1023, 10'd1023, 10'd1023, 10'd0, 10'd0, 10'd1023);
    endtask

    task automatic test_top_left_ties();
        send_triangle(10'd16, 10'd16, 10'd160, 10'd16, 10'd16, 10'd160);
        send_triangle(10'd16, 10'd16, 10'd16, 10'd160, 10'd160, 10'd16);
        send_triangle(10'd160, 10'd16, 10'd160, 10'd160, 10'd16, 10'd160);
        send_triangle(10'd160, 10'd16, 10'd16, 10'd160, 10'd160, 10'd160);
        send_triangle(10'd80, 10'd16, 10'd160, 10'd160, 10'd16, 10'd160);
        send_triangle(10'd80, 10'd16, 10'd16, 10'd160, 10'd160, 10'd160);
    endtask

    task automatic test_degenerate();
        send_triangle(10'd32, 10'd32, 10'd32, 10'd32, 10'd32, 10'd32);
        send_triangle(10'd0, 10'd0, 10'd512, 10'd512, 10'd1023, 10'd1023);
        send_triangle(10'd100, 10'd200, 10'd100, 10'd200, 10'd600, 10'd700);
        send_triangle(10'd48, 10'd48, 10'd480, 10'd48, 10'd960, 10'd48);
    endtask

    task automatic test_random_triangles();
        int     n, i, pick, spread, x0, y0, snap;
        t_coord v[6];
        for (n = 0; n < RANDOM_TRIANGLES; n++) begin
            steady = (n >= 120 && n < 150);
            pick   = $urandom_range(0, 99);
            spread = (pick < 65) ? $urandom_range(8, 128) : $urandom_range(128, 400);
            x0     = $urandom_range(0, 1023);
            y0     = $urandom_range(0, 1023);
            for (i = 0; i < 6; i += 2) begin
                v[i]     = clamp_coord(x0, spread);
                v[i + 1] = clamp_coord(y0, spread);
            end
            if (pick >= 50 && pick < 65) begin
                snap = $urandom_range(0, 1) ? 15 : 7;
                for (i = 0; i < 6; i++) v[i] = v[i] & ~t_coord'(snap);
            end else if (pick >= 80 && pick < 85) begin
                for (i = 0; i < 6; i++) v[i] = t_coord'($urandom_range(0, 1023));
            end else if (pick >= 85) begin
                case ($urandom_range(0, 3))
                    0: begin
                        v[3] = v[1];
                    end
                    1: begin
                        v[4] = v[0];
                    end
                    2: begin
                        v[4] = v[2];
                        v[5] = v[3];
                    end
                    default: begin
                        v[4] = t_coord'((int'(v[0]) + int'(v[2])) / 2);
                        v[5] = t_coord'((int'(v[1]) + int'(v[3])) / 2);
                    end
                endcase
            end
            send_triangle(v[0], v[1], v[2], v[3], v[4], v[5]);
        end
        steady = 1'b0;
    endtask

    task automatic finish_run();
        i_in_valid <= 1'b0;
        while (expected_rows.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Sent %0d triangles and checked %0d row masks, %0d of them with coverage.",
                 triangles_sent, rows_checked, covered_rows);
        $display("Directed cases: empty boxes, zero-width boxes, full screen, top-left ties.");
        if (mismatches == 0 && expected_rows.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("%0d mismatches, %0d rows never arrived",
                     mismatches, expected_rows.size());
            $display("Verification failed");
        end
        $finish;
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_boxes();
        test_zero_width();
        test_full_screen();
        test_top_left_ties();
        test_degenerate();
        test_random_triangles();
        finish_run();
    end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/hstr_pkg.sv
hw/rtl/hstr_edge_unit.sv
hw/rtl/hstr_seq.sv
hw/rtl/half_space_triangle_rasterizer.sv
dv/tb_top.sv
